// File: rtl/ffa_pkg.sv
// Shared types and constants for the first-fit extent allocator.
// No dependencies.
package ffa_pkg;

    localparam int MAX_EXTENTS_DEF = 64;
    localparam int WORD_BYTES = 4;
    localparam int HEAP_BYTES = 65536;
    localparam int CELL_SLOTS = 16384;
    localparam int CS_AW = 14;
    localparam logic [16:0] HEADER_BYTES = 17'd4;
    localparam logic [16:0] MIN_CELL = 17'd8;
    localparam logic [16:0] LEN_MAX = 17'h1FFFF;
    localparam logic [15:0] HEAP_BASE_RST = 16'd1024;
    localparam logic [16:0] HEAP_LIMIT_RST = 17'(HEAP_BYTES % 131072);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEN,
        S_SCAN,
        S_OUT
    } state_t;

    function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [16:0] b);
        logic [17:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[17] ? LEN_MAX : s[16:0];
    endfunction

endpackage

// File: rtl/ffa_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/first_fit_extent_allocator.sv
// First-fit extent allocator top level: control, extent table and cell size store.
// Depends on ffa_pkg and ffa_ram.
//
// Usage:
// Requests enter on in_valid/in_stall with op, request_size and object_address.
// Each request yields exactly one result on out_valid/out_stall carrying
// granted_address and status. One request is handled at a time: in_stall is
// high from acceptance until the result has been taken.
// The result comes from a walk over the extent table memory, one entry per
// cycle through its single read port; merges and shifts are done by writing
// back behind the read pointer.
// A free of address 0 or with a full table skips the walk and answers in the
// cycle after acceptance.
// The result is held in an output register while out_stall is high.
// Reset empties the extent table (count only), sets the break pointer to 1024 and
// the heap limit to the heap size. Writing heap_base also loads the break pointer.
// Configuration must be written only while the block is idle; the user sees to it.
module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [15:0] request_size,
    input  logic [15:0] object_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] granted_address,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_EXTENTS);

    ffa_pkg::state_t state_reg, state_next;
    logic            op_reg, op_next;
    logic [16:0]     need_reg, need_next;
    logic [15:0]     cell_reg, cell_next;
    logic [CW-1:0]   rd_reg, rd_next;
    logic [AW-1:0]   pidx_reg, pidx_next;
    logic            dv_reg, dv_next;
    logic [CW-1:0]   w_reg, w_next;
    logic            have_reg, have_next;
    logic            copy_reg, copy_next;
    logic            ins_reg, ins_next;
    logic [15:0]     cur_s_reg, cur_s_next;
    logic [16:0]     cur_l_reg, cur_l_next;
    logic [15:0]     car_s_reg, car_s_next;
    logic [16:0]     car_l_reg, car_l_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [16:0]     bp_reg, bp_next;
    logic [16:0]     lim_reg, lim_next;
    logic [15:0]     res_a_reg, res_a_next;
    logic [1:0]      res_s_reg, res_s_next;

    logic            ext_we;
    logic [AW-1:0]   ext_waddr, ext_raddr;
    logic [32:0]     ext_wdata, ext_rdata;
    logic            cs_we;
    logic [ffa_pkg::CS_AW-1:0] cs_waddr, cs_raddr;
    logic [16:0]     cs_wdata, cs_rdata;

    logic [15:0]     e_s;
    logic [16:0]     e_l;
    logic [17:0]     cur_end;
    logic [16:0]     req_hdr, req_min, need_in;
    logic            done;
    logic            brk_join;
    logic [16:0]     tk_l;
    logic            tk_split;
    logic [17:0]     tk_s_need, need_plus;
    logic [17:0]     brk_sum;
    logic [15:0]     cs_cell_in;

    ffa_ram #(.WIDTH(33), .DEPTH(MAX_EXTENTS)) u_ext (
        .clk(clk), .we(ext_we), .waddr(ext_waddr), .wdata(ext_wdata),
        .raddr(ext_raddr), .rdata(ext_rdata)
    );

    ffa_ram #(.WIDTH(17), .DEPTH(ffa_pkg::CELL_SLOTS)) u_cls (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata)
    );

    assign e_s      = ext_rdata[32:17];
    assign e_l      = ext_rdata[16:0];
    assign cur_end  = {2'b00, cur_s_reg} + {1'b0, cur_l_reg};
    assign req_hdr  = {1'b0, request_size} + ffa_pkg::HEADER_BYTES;
    assign req_min  = (req_hdr < ffa_pkg::MIN_CELL) ? ffa_pkg::MIN_CELL : req_hdr;
    assign need_in  = (req_min + 17'(ffa_pkg::WORD_BYTES - 1))
                      & ~17'(ffa_pkg::WORD_BYTES - 1);
    assign done     = (state_reg == ffa_pkg::S_SCAN) && !dv_reg && (rd_reg == cnt_reg);
    assign brk_sum  = {1'b0, bp_reg} + {1'b0, need_reg};
    assign brk_join = done && have_reg && !(need_reg <= cur_l_reg) &&
                      (cur_end == {1'b0, bp_reg});
    assign tk_l     = brk_join ? ffa_pkg::sat_add(cur_l_reg, need_reg) : cur_l_reg;
    assign need_plus = {1'b0, need_reg} + {1'b0, ffa_pkg::MIN_CELL};
    assign tk_s_need = {2'b00, cur_s_reg} + {1'b0, need_reg};
    assign tk_split = ({1'b0, tk_l} >= need_plus) && (tk_s_need <= 18'h0FFFF);
    assign cs_cell_in = object_address - 16'(ffa_pkg::HEADER_BYTES);

    assign in_stall        = (state_reg != ffa_pkg::S_IDLE);
    assign out_valid       = (state_reg == ffa_pkg::S_OUT);
    assign granted_address = res_a_reg;
    assign status          = res_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffa_pkg::S_IDLE;
            cnt_reg   <= '0;
            bp_reg    <= {1'b0, ffa_pkg::HEAP_BASE_RST};
            lim_reg   <= ffa_pkg::HEAP_LIMIT_RST;
            dv_reg    <= 1'b0;
            rd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bp_reg    <= bp_next;
            lim_reg   <= lim_next;
            dv_reg    <= dv_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        need_reg  <= need_next;
        cell_reg  <= cell_next;
        pidx_reg  <= pidx_next;
        w_reg     <= w_next;
        have_reg  <= have_next;
        copy_reg  <= copy_next;
        ins_reg   <= ins_next;
        cur_s_reg <= cur_s_next;
        cur_l_reg <= cur_l_next;
        car_s_reg <= car_s_next;
        car_l_reg <= car_l_next;
        res_a_reg <= res_a_next;
        res_s_reg <= res_s_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        need_next  = need_reg;
        cell_next  = cell_reg;
        rd_next    = rd_reg;
        pidx_next  = pidx_reg;
        dv_next    = 1'b0;
        w_next     = w_reg;
        have_next  = have_reg;
        copy_next  = copy_reg;
        ins_next   = ins_reg;
        cur_s_next = cur_s_reg;
        cur_l_next = cur_l_reg;
        car_s_next = car_s_reg;
        car_l_next = car_l_reg;
        cnt_next   = cnt_reg;
        bp_next    = bp_reg;
        lim_next   = lim_reg;
        res_a_next = res_a_reg;
        res_s_next = res_s_reg;
        ext_we     = 1'b0;
        ext_waddr  = w_reg[AW-1:0];
        ext_wdata  = {cur_s_reg, cur_l_reg};
        ext_raddr  = rd_reg[AW-1:0];
        cs_we      = 1'b0;
        cs_waddr   = cur_s_reg[15:2];
        cs_wdata   = tk_split ? need_reg : tk_l;
        cs_raddr   = cs_cell_in[15:2];

        if (cfg_we)
        begin
            unique case (ffa_pkg::cfg_idx_t'(cfg_index))
                ffa_pkg::CFG_HEAP_BASE:  bp_next = {1'b0, cfg_data[15:0]};
                ffa_pkg::CFG_HEAP_LIMIT: lim_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    need_next  = need_in;
                    cell_next  = cs_cell_in;
                    res_a_next = '0;
                    res_s_next = ffa_pkg::ST_OK;
                    if (op == ffa_pkg::OP_FREE && object_address == 16'd0)
                    begin
                        state_next = ffa_pkg::S_OUT;
                    end
                    else if (op == ffa_pkg::OP_FREE && cnt_reg == CNT_FULL)
                    begin
                        res_s_next = ffa_pkg::ST_FULL;
                        state_next = ffa_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = ffa_pkg::S_CLEN;
                    end
                end
            end

            ffa_pkg::S_CLEN:
            begin
                car_s_next = cell_reg;
                car_l_next = cs_rdata;
                have_next  = 1'b0;
                copy_next  = 1'b0;
                ins_next   = 1'b0;
                w_next     = '0;
                ext_raddr  = '0;
                pidx_next  = '0;
                rd_next    = (cnt_reg != '0) ? CW'(1) : '0;
                dv_next    = (cnt_reg != '0);
                state_next = ffa_pkg::S_SCAN;
            end

            ffa_pkg::S_SCAN:
            begin
                if (rd_reg < cnt_reg)
                begin
                    rd_next   = rd_reg + CW'(1);
                    dv_next   = 1'b1;
                    pidx_next = rd_reg[AW-1:0];
                end

                if (dv_reg)
                begin
                    if (op_reg == ffa_pkg::OP_FREE)
                    begin
                        if (ins_reg || e_s >= cell_reg)
                        begin
                            ext_we     = 1'b1;
                            ext_waddr  = pidx_reg;
                            ext_wdata  = {car_s_reg, car_l_reg};
                            car_s_next = e_s;
                            car_l_next = e_l;
                            ins_next   = 1'b1;
                        end
                    end
                    else if (copy_reg)
                    begin
                        ext_we     = 1'b1;
                        ext_wdata  = {car_s_reg, car_l_reg};
                        w_next     = w_reg + CW'(1);
                        car_s_next = e_s;
                        car_l_next = e_l;
                    end
                    else if (!have_reg)
                    begin
                        have_next  = 1'b1;
                        cur_s_next = e_s;
                        cur_l_next = e_l;
                    end
                    else if (cur_end == {2'b00, e_s})
                    begin
                        cur_l_next = ffa_pkg::sat_add(cur_l_reg, e_l);
                    end
                    else if (need_reg <= cur_l_reg)
                    begin
                        cs_we      = 1'b1;
                        res_a_next = cur_s_reg + ffa_pkg::HEADER_BYTES[15:0];
                        res_s_next = ffa_pkg::ST_OK;
                        if (tk_split)
                        begin
                            ext_we    = 1'b1;
                            ext_wdata = {tk_s_need[15:0], tk_l - need_reg};
                            w_next    = w_reg + CW'(1);
                        end
                        copy_next  = 1'b1;
                        car_s_next = e_s;
                        car_l_next = e_l;
                    end
                    else
                    begin
                        ext_we     = 1'b1;
                        w_next     = w_reg + CW'(1);
                        cur_s_next = e_s;
                        cur_l_next = e_l;
                    end
                end

                if (done)
                begin
                    state_next = ffa_pkg::S_OUT;
                    if (op_reg == ffa_pkg::OP_FREE)
                    begin
                        ext_we    = 1'b1;
                        ext_waddr = cnt_reg[AW-1:0];
                        ext_wdata = {car_s_reg, car_l_reg};
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    else if (copy_reg)
                    begin
                        ext_we    = 1'b1;
                        ext_wdata = {car_s_reg, car_l_reg};
                        cnt_next  = w_reg + CW'(1);
                    end
                    else if ((have_reg && need_reg <= cur_l_reg) ||
                             (brk_join && brk_sum <= {1'b0, lim_reg}))
                    begin
                        if (brk_join && !(need_reg <= cur_l_reg))
                        begin
                            bp_next = brk_sum[16:0];
                        end
                        cs_we      = 1'b1;
                        res_a_next = cur_s_reg + ffa_pkg::HEADER_BYTES[15:0];
                        res_s_next = ffa_pkg::ST_OK;
                        if (tk_split)
                        begin
                            ext_we    = 1'b1;
                            ext_wdata = {tk_s_need[15:0], tk_l - need_reg};
                            cnt_next  = w_reg + CW'(1);
                        end
                        else
                        begin
                            cnt_next  = w_reg;
                        end
                    end
                    else
                    begin
                        if (have_reg)
                        begin
                            ext_we   = 1'b1;
                            cnt_next = w_reg + CW'(1);
                        end
                        else
                        begin
                            cnt_next = w_reg;
                        end
                        if (brk_sum > {1'b0, lim_reg})
                        begin
                            res_a_next = '0;
                            res_s_next = ffa_pkg::ST_OOM;
                        end
                        else
                        begin
                            bp_next    = brk_sum[16:0];
                            cs_we      = 1'b1;
                            cs_waddr   = bp_reg[15:2];
                            cs_wdata   = need_reg;
                            res_a_next = bp_reg[15:0] + ffa_pkg::HEADER_BYTES[15:0];
                            res_s_next = ffa_pkg::ST_OK;
                        end
                    end
                end
            end

            ffa_pkg::S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ffa_pkg::S_IDLE;
                end
            end

            default: state_next = ffa_pkg::S_IDLE;
        endcase
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("extent count beyond table depth");

    a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffa_pkg::S_SCAN && ext_we && !done && op_reg == ffa_pkg::OP_ALLOC)
        |-> (CW'(ext_waddr) < rd_reg))
        else $error("table write ahead of read pointer");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ffa_pkg::ST_OK || status == ffa_pkg::ST_OOM ||
                       status == ffa_pkg::ST_FULL))
        else $error("illegal status");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ffa_pkg::ST_OK) |-> (granted_address == 16'd0))
        else $error("failed request carries an address");

endmodule
